// ===== rtl/cube_grid_simplex_emitter_macros.svh =====
// ----------------------------------------------------------------------------
// Cube grid simplex emitter assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CUBE_GRID_SIMPLEX_EMITTER_MACROS_SVH
`define CUBE_GRID_SIMPLEX_EMITTER_MACROS_SVH

// same-cycle implication
`define CGSE_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define CGSE_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/cgse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cube grid simplex emitter package
// Widths, register indexes, permutation types and the permutation stepper.
// ----------------------------------------------------------------------------
package cgse_pkg;

   localparam int unsigned NUM_AXES     = 4;
   localparam int unsigned NUM_VERTICES = 5;
   localparam int unsigned COORD_W      = 8;
   localparam int unsigned INDEX_W      = 32;
   localparam int unsigned FACTOR_W     = COORD_W + 1;
   localparam int unsigned CSR_INDEX_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_CUBES_AXIS_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUBES_AXIS_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUBES_AXIS_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUBES_AXIS_3 = 3'd3;

   typedef logic [NUM_AXES-1:0][1:0] axis_order_type;

   typedef struct packed {
      axis_order_type order;
      logic           more;
   } perm_step_type;

   function automatic axis_order_type perm_identity();
      axis_order_type r;
      for (int i = 0; i < NUM_AXES; i++) begin
         r[i] = 2'(i);
      end
      return r;
   endfunction

   // next permutation of the first n entries in lexicographic order
   function automatic perm_step_type perm_advance(axis_order_type a, int unsigned n);
      perm_step_type  r;
      axis_order_type b;
      logic           found;
      logic [1:0]     piv;
      logic [1:0]     sw;
      found = 1'b0;
      piv   = 2'd0;
      for (int i = 1; i < NUM_AXES; i++) begin
         if (i < n && a[i-1] < a[i]) begin
            found = 1'b1;
            piv   = 2'(i - 1);
         end
      end
      sw = piv;
      for (int j = 0; j < NUM_AXES; j++) begin
         if (j < n && j > int'(piv) && a[j] > a[piv]) begin
            sw = 2'(j);
         end
      end
      b      = a;
      b[piv] = a[sw];
      b[sw]  = a[piv];
      r.order = b;
      for (int k = 0; k < NUM_AXES; k++) begin
         if (k > int'(piv) && k < n) begin
            r.order[k] = b[2'(int'(n) + int'(piv) - k)];
         end
      end
      if (!found) begin
         r.order = a;
      end
      r.more = found;
      return r;
   endfunction

endpackage

// ===== rtl/cgse_mac.sv =====
// ----------------------------------------------------------------------------
// Cube grid simplex emitter multiply-add unit
// Shared a * b + c, modulo 2^32, used for strides and the corner index.
// ----------------------------------------------------------------------------
module cgse_mac
   import cgse_pkg::*;
(
   input  logic [INDEX_W-1:0]  mul_a,
   input  logic [FACTOR_W-1:0] mul_b,
   input  logic [INDEX_W-1:0]  add_c,
   output logic [INDEX_W-1:0]  result
);

   logic [INDEX_W+FACTOR_W-1:0] product;

   assign product = mul_a * mul_b;
   assign result  = product[INDEX_W-1:0] + add_c;

endmodule

// ===== rtl/cube_grid_simplex_emitter.sv =====
// ----------------------------------------------------------------------------
// Cube grid simplex emitter
// Emits the DIM! simplices of one grid cube, one path vertex per cycle.
//
//   channel  direction  handshake                    payload
//   req      in         req_valid / req_stall        req_coord_0..3
//   rsp      out        rsp_valid / rsp_stall        rsp_vertex_0..4, rsp_last_simplex
//   csr      in         csr_write_enable             csr_index, csr_write_data
//
// One item: an accept step, stride steps and corner steps on the
// shared multiply-add unit, then DIM! simplices, each one adder step per
// path vertex plus a load into the output register.
// A corner outside the grid is taken and emits nothing.
// Reset is synchronous; there is no clearing pass.
// A stalled output holds the simplex unit in its load cycle until taken.
// ----------------------------------------------------------------------------
`include "cube_grid_simplex_emitter_macros.svh"

module cube_grid_simplex_emitter
   import cgse_pkg::*;
#(
   parameter int unsigned DIM = 3
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_W-1:0]     req_coord_0,
   input  logic [COORD_W-1:0]     req_coord_1,
   input  logic [COORD_W-1:0]     req_coord_2,
   input  logic [COORD_W-1:0]     req_coord_3,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [INDEX_W-1:0]     rsp_vertex_0,
   output logic [INDEX_W-1:0]     rsp_vertex_1,
   output logic [INDEX_W-1:0]     rsp_vertex_2,
   output logic [INDEX_W-1:0]     rsp_vertex_3,
   output logic [INDEX_W-1:0]     rsp_vertex_4,
   output logic                   rsp_last_simplex,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_write_data
);

   localparam int unsigned NDIM      = (DIM > 4) ? 4 : ((DIM < 1) ? 1 : DIM);
   localparam logic [1:0]  LAST_AXIS = 2'(NDIM - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_STRIDE = 3'd1;
   localparam logic [2:0] S_CORNER = 3'd2;
   localparam logic [2:0] S_PATH   = 3'd3;
   localparam logic [2:0] S_PUSH   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         idx_ff, idx_in;
   logic [1:0]         k_ff, k_in;
   logic [INDEX_W-1:0] acc_ff, acc_in;
   logic [INDEX_W-1:0] corner_ff, corner_in;
   logic [INDEX_W-1:0] run_ff, run_in;
   logic [INDEX_W-1:0] stride_ff [NUM_AXES];
   logic [INDEX_W-1:0] stride_in [NUM_AXES];
   logic [INDEX_W-1:0] vtx_ff [NUM_AXES];
   logic [INDEX_W-1:0] vtx_in [NUM_AXES];
   logic [COORD_W-1:0] coord_ff [NUM_AXES];
   logic [COORD_W-1:0] coord_in [NUM_AXES];
   logic [COORD_W-1:0] cubes_ff [NUM_AXES];
   logic [COORD_W-1:0] cubes_in [NUM_AXES];
   axis_order_type     order_ff, order_in;
   logic [INDEX_W-1:0] rsp_vtx_ff [NUM_VERTICES];
   logic [INDEX_W-1:0] rsp_vtx_in [NUM_VERTICES];
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   perm_step_type      perm_next;
   logic               in_range;
   logic               req_take;
   logic               push_go;
   logic [FACTOR_W-1:0] mac_b;
   logic [INDEX_W-1:0] mac_c;
   logic [INDEX_W-1:0] mac_out;
   logic [INDEX_W-1:0] stride_sel;

   assign coord_in[0] = req_coord_0;
   assign coord_in[1] = req_coord_1;
   assign coord_in[2] = req_coord_2;
   assign coord_in[3] = req_coord_3;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign push_go   = (state_ff == S_PUSH) && (!rsp_valid_ff || !rsp_stall);
   assign perm_next = perm_advance(order_ff, NDIM);

   always_comb begin
      in_range = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (i < NDIM && coord_in[i] >= cubes_ff[i]) begin
            in_range = 1'b0;
         end
      end
   end

   assign mac_b = {1'b0, cubes_ff[idx_ff]} + FACTOR_W'(1);
   assign mac_c = (state_ff == S_CORNER) ? INDEX_W'(coord_ff[idx_ff]) : '0;
   assign stride_sel = stride_ff[LAST_AXIS - order_ff[k_ff]];

   cgse_mac u_mac (
      .mul_a  (acc_ff),
      .mul_b  (mac_b),
      .add_c  (mac_c),
      .result (mac_out)
   );

   always_comb begin
      cubes_in = cubes_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CUBES_AXIS_0: cubes_in[0] = csr_write_data;
            CSR_CUBES_AXIS_1: cubes_in[1] = csr_write_data;
            CSR_CUBES_AXIS_2: cubes_in[2] = csr_write_data;
            CSR_CUBES_AXIS_3: cubes_in[3] = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      corner_in = corner_ff;
      run_in    = run_ff;
      stride_in = stride_ff;
      vtx_in    = vtx_ff;
      order_in  = order_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && in_range) begin
               stride_in[LAST_AXIS] = INDEX_W'(1);
               order_in             = perm_identity();
               k_in                 = 2'd0;
               if (NDIM > 1) begin
                  acc_in   = INDEX_W'(1);
                  idx_in   = LAST_AXIS;
                  state_in = S_STRIDE;
               end else begin
                  corner_in = INDEX_W'(coord_in[0]);
                  run_in    = INDEX_W'(coord_in[0]);
                  state_in  = S_PATH;
               end
            end
         end
         S_STRIDE: begin
            stride_in[idx_ff - 2'd1] = mac_out;
            acc_in                   = mac_out;
            if (idx_ff == 2'd1) begin
               acc_in   = INDEX_W'(coord_ff[0]);
               state_in = S_CORNER;
            end else begin
               idx_in = idx_ff - 2'd1;
            end
         end
         S_CORNER: begin
            acc_in = mac_out;
            if (idx_ff == LAST_AXIS) begin
               corner_in = mac_out;
               run_in    = mac_out;
               k_in      = 2'd0;
               state_in  = S_PATH;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_PATH: begin
            run_in       = run_ff + stride_sel;
            vtx_in[k_ff] = run_ff + stride_sel;
            if (k_ff == LAST_AXIS) begin
               state_in = S_PUSH;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_PUSH: begin
            if (push_go) begin
               if (perm_next.more) begin
                  order_in = perm_next.order;
                  run_in   = corner_ff;
                  k_in     = 2'd0;
                  state_in = S_PATH;
               end else begin
                  order_in = perm_identity();
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_vtx_in   = rsp_vtx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (push_go) begin
         rsp_valid_in  = 1'b1;
         rsp_last_in   = !perm_next.more;
         rsp_vtx_in[0] = corner_ff;
         for (int v = 1; v < NUM_VERTICES; v++) begin
            rsp_vtx_in[v] = (v <= NDIM) ? vtx_ff[v-1] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= 2'd0;
         k_ff         <= 2'd0;
         order_ff     <= perm_identity();
         corner_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            cubes_ff[i] <= COORD_W'(1);
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         order_ff     <= order_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         cubes_ff     <= cubes_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      run_ff      <= run_in;
      stride_ff   <= stride_in;
      vtx_ff      <= vtx_in;
      rsp_vtx_ff  <= rsp_vtx_in;
      rsp_last_ff <= rsp_last_in;
      if (req_take) begin
         coord_ff <= coord_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_0     = rsp_vtx_ff[0];
   assign rsp_vertex_1     = rsp_vtx_ff[1];
   assign rsp_vertex_2     = rsp_vtx_ff[2];
   assign rsp_vertex_3     = rsp_vtx_ff[3];
   assign rsp_vertex_4     = rsp_vtx_ff[4];
   assign rsp_last_simplex = rsp_last_ff;

   `CGSE_ASSERT_NEXT(a_start_on_inside_corner, req_take && in_range,
      state_ff != S_IDLE, "inside corner did not start emission")
   `CGSE_ASSERT_NEXT(a_last_returns_idle, push_go && !perm_next.more,
      state_ff == S_IDLE && rsp_last_simplex && order_ff == perm_identity(),
      "final simplex did not return to idle")
   `CGSE_ASSERT_IMPLY(a_path_rises, rsp_valid_ff, rsp_vtx_ff[1] > rsp_vtx_ff[0],
      "first path step does not rise above corner")

endmodule
